// ===== sv/four_level_page_table_engine_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Page table engine assertion macros
// Clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_ENGINE_UNIT_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication
`define FLPT_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FLPT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/flpt_pkg.sv =====
// ----------------------------------------------------------------------------
// flpt_pkg
// Shared codes and types of the four-level page table engine.
// ----------------------------------------------------------------------------
package flpt_pkg;

    localparam int VA_W    = 48;
    localparam int FRAME_W = 36;
    localparam int PTE_W   = 64;
    localparam int IDX_W   = 9;
    localparam int ROOT_W  = 6;

    localparam logic [1:0] CMD_MAP   = 2'd0;
    localparam logic [1:0] CMD_UNMAP = 2'd1;
    localparam logic [1:0] CMD_XLATE = 2'd2;

    localparam logic [1:0] STS_OK         = 2'd0;
    localparam logic [1:0] STS_NOT_MAPPED = 2'd1;
    localparam logic [1:0] STS_EXHAUSTED  = 2'd2;

    localparam logic REG_REGION_FRAME = 1'b0;
    localparam logic REG_ROOT_PAGE    = 1'b1;

    typedef struct packed {
        logic [FRAME_W-1:0] region_frame;
        logic [ROOT_W-1:0]  root_page;
    } cfg_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [VA_W-1:0] addr;
    } result_t;

endpackage

// ===== sv/flpt_store.sv =====
// ----------------------------------------------------------------------------
// flpt_store
// Single-port table store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module flpt_store #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic          rd_en,
    input  logic [AW-1:0] addr,
    input  logic [63:0]   wdata,
    output logic [63:0]   rdata
);

    logic [63:0] mem_array [DEPTH];
    logic [63:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[addr] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem_array[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/flpt_walker.sv =====
// ----------------------------------------------------------------------------
// flpt_walker
// Command sequencer: clears the store, walks the four levels per page,
// allocates and zeroes table pages, writes leaf entries.
// ----------------------------------------------------------------------------
module flpt_walker #(
    parameter int NUM_TABLE_PAGES = 64,
    parameter int PW              = 6,
    parameter int AW              = 15
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        in_cmd,
    input  logic [flpt_pkg::VA_W-1:0]         in_va,
    input  logic [flpt_pkg::FRAME_W-1:0]      in_pf,
    input  logic [1:0]                        in_af,
    input  logic [15:0]                       in_count,
    input  flpt_pkg::cfg_t                    cfg,
    output logic                              res_valid,
    input  logic                              res_ready,
    output flpt_pkg::result_t                 res,
    output logic                              mem_wr_en,
    output logic                              mem_rd_en,
    output logic [AW-1:0]                     mem_addr,
    output logic [63:0]                       mem_wdata,
    input  logic [63:0]                       mem_rdata
);
    import flpt_pkg::*;

    localparam int DEPTH = NUM_TABLE_PAGES * 512;
    localparam int NFW   = $clog2(NUM_TABLE_PAGES + 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_PAGE  = 4'd2;
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_EVAL  = 4'd4;
    localparam logic [3:0] S_ZERO  = 4'd5;
    localparam logic [3:0] S_LINK  = 4'd6;
    localparam logic [3:0] S_LEAF  = 4'd7;
    localparam logic [3:0] S_NEXT  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]         state_reg, state_next;
    logic [1:0]         cmd_reg, cmd_next;
    logic [VA_W-1:0]    va_reg, va_next;
    logic [FRAME_W-1:0] pf_reg, pf_next;
    logic [1:0]         fl_reg, fl_next;
    logic [15:0]        count_reg, count_next;
    logic [1:0]         level_reg, level_next;
    logic [PW-1:0]      page_reg, page_next;
    logic [NFW-1:0]     next_free_reg, next_free_next;
    logic [AW-1:0]      sweep_reg, sweep_next;
    result_t            res_reg, res_next;

    logic               root_ok;
    logic [PW-1:0]      root_page;
    logic [IDX_W-1:0]   idx;
    logic [AW-1:0]      cur_addr;
    logic [FRAME_W-1:0] off;
    logic               in_region;
    logic               pool_empty;
    logic [PW-1:0]      new_page;
    logic [FRAME_W-1:0] new_frame;
    logic [2:0]         fl_bits;

    assign root_ok    = 32'(cfg.root_page) < 32'(NUM_TABLE_PAGES);
    assign root_page  = PW'(cfg.root_page);
    assign cur_addr   = {page_reg, idx};
    assign off        = mem_rdata[47:12] - cfg.region_frame;
    assign in_region  = off < FRAME_W'(NUM_TABLE_PAGES);
    assign pool_empty = next_free_reg >= NFW'(NUM_TABLE_PAGES);
    assign new_page   = next_free_reg[PW-1:0];
    assign new_frame  = cfg.region_frame + FRAME_W'(next_free_reg);
    assign fl_bits    = {fl_reg, 1'b0};

    always_comb begin
        case (level_reg)
            2'd0:    idx = va_reg[47:39];
            2'd1:    idx = va_reg[38:30];
            2'd2:    idx = va_reg[29:21];
            default: idx = va_reg[20:12];
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        va_next        = va_reg;
        pf_next        = pf_reg;
        fl_next        = fl_reg;
        count_next     = count_reg;
        level_next     = level_reg;
        page_next      = page_reg;
        next_free_next = next_free_reg;
        sweep_next     = sweep_reg;
        res_next       = res_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        mem_wr_en      = 1'b0;
        mem_rd_en      = 1'b0;
        mem_addr       = cur_addr;
        mem_wdata      = '0;

        unique case (state_reg)
            S_CLEAR: begin
                mem_wr_en  = 1'b1;
                mem_addr   = sweep_reg;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == AW'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd_next   = in_cmd;
                    va_next    = (in_cmd == CMD_XLATE) ? in_va : {in_va[VA_W-1:12], 12'h000};
                    pf_next    = in_pf;
                    fl_next    = in_af;
                    count_next = in_count;
                    state_next = S_PAGE;
                end
            end
            S_PAGE: begin
                level_next = 2'd0;
                page_next  = root_page;
                unique case (cmd_reg)
                    CMD_XLATE: begin
                        if (!root_ok) begin
                            res_next   = '{status: STS_NOT_MAPPED, addr: '0};
                            state_next = S_DONE;
                        end else begin
                            state_next = S_READ;
                        end
                    end
                    CMD_MAP: begin
                        if (count_reg == 16'd0) begin
                            res_next   = '{status: STS_OK, addr: va_reg};
                            state_next = S_DONE;
                        end else if (!root_ok) begin
                            res_next   = '{status: STS_EXHAUSTED, addr: va_reg};
                            state_next = S_DONE;
                        end else begin
                            state_next = S_READ;
                        end
                    end
                    CMD_UNMAP: begin
                        if (count_reg == 16'd0) begin
                            res_next   = '{status: STS_OK, addr: va_reg};
                            state_next = S_DONE;
                        end else if (!root_ok) begin
                            state_next = S_NEXT;
                        end else begin
                            state_next = S_READ;
                        end
                    end
                    default: begin
                        res_next   = '{status: STS_OK, addr: '0};
                        state_next = S_DONE;
                    end
                endcase
            end
            S_READ: begin
                mem_rd_en  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                unique case (cmd_reg)
                    CMD_XLATE: begin
                        if (level_reg == 2'd3) begin
                            if (mem_rdata[0]) begin
                                res_next = '{status: STS_OK,
                                             addr: {mem_rdata[47:12], va_reg[11:0]}};
                            end else begin
                                res_next = '{status: STS_NOT_MAPPED, addr: '0};
                            end
                            state_next = S_DONE;
                        end else if (mem_rdata == 64'd0 || !in_region) begin
                            res_next   = '{status: STS_NOT_MAPPED, addr: '0};
                            state_next = S_DONE;
                        end else begin
                            page_next  = off[PW-1:0];
                            level_next = level_reg + 2'd1;
                            state_next = S_READ;
                        end
                    end
                    CMD_UNMAP: begin
                        if (mem_rdata[0] && in_region) begin
                            page_next  = off[PW-1:0];
                            level_next = level_reg + 2'd1;
                            state_next = (level_reg == 2'd2) ? S_LEAF : S_READ;
                        end else begin
                            state_next = S_NEXT;
                        end
                    end
                    CMD_MAP: begin
                        if (mem_rdata[0] && in_region) begin
                            mem_wr_en  = 1'b1;
                            mem_wdata  = mem_rdata | {61'd0, fl_bits};
                            page_next  = off[PW-1:0];
                            level_next = level_reg + 2'd1;
                            state_next = (level_reg == 2'd2) ? S_LEAF : S_READ;
                        end else if (pool_empty) begin
                            res_next   = '{status: STS_EXHAUSTED, addr: va_reg};
                            state_next = S_DONE;
                        end else begin
                            sweep_next = '0;
                            state_next = S_ZERO;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_ZERO: begin
                // new table page must read as all zero before it is linked
                mem_wr_en  = 1'b1;
                mem_addr   = {new_page, sweep_reg[IDX_W-1:0]};
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg[IDX_W-1:0] == '1) begin
                    state_next = S_LINK;
                end
            end
            S_LINK: begin
                mem_wr_en      = 1'b1;
                mem_wdata      = {16'd0, new_frame, 9'd0, fl_bits | 3'b001};
                page_next      = new_page;
                next_free_next = next_free_reg + 1'b1;
                level_next     = level_reg + 2'd1;
                state_next     = (level_reg == 2'd2) ? S_LEAF : S_READ;
            end
            S_LEAF: begin
                mem_wr_en  = 1'b1;
                mem_wdata  = (cmd_reg == CMD_MAP) ?
                             {16'd0, pf_reg, 9'd0, fl_bits | 3'b001} : 64'd0;
                state_next = S_NEXT;
            end
            S_NEXT: begin
                va_next    = va_reg + 48'h1000;
                pf_next    = pf_reg + 1'b1;
                count_next = count_reg - 1'b1;
                state_next = S_PAGE;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            next_free_reg <= NFW'(1);
            sweep_reg     <= '0;
            level_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            sweep_reg     <= sweep_next;
            level_reg     <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        va_reg    <= va_next;
        pf_reg    <= pf_next;
        fl_reg    <= fl_next;
        count_reg <= count_next;
        page_reg  <= page_next;
        res_reg   <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== sv/four_level_page_table_engine_unit.sv =====
// Sequence: translate goes through PAGE, then a read/evaluate per table level; map and unmap
// go per page through PAGE, read/evaluate per table level, leaf write, step, plus a zeroing
// pass and link write for each table page taken from the pool; then into the output register.
// One command at a time; the single store port sets the pace.
// Reset: synchronous; then a clearing pass over all NUM_TABLE_PAGES*512 store words
// (32768 by default) zeroes the store with s_tready low.
// ----------------------------------------------------------------------------
// four_level_page_table_engine_unit
// Top level: config registers, table store, walker and result register.
// ----------------------------------------------------------------------------
module four_level_page_table_engine_unit #(
    parameter int NUM_TABLE_PAGES = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vaddr[47:0], phys_frame[83:48], access_flags[85:84], npages[101:86]
    input  logic [103:0] s_tdata,
    // command
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_addr
    output logic [47:0]  m_tdata,
    // status
    output logic [1:0]   m_tuser,
    input  logic         cfg_wen,
    input  logic         cfg_idx,
    input  logic [35:0]  cfg_wdata
);
    import flpt_pkg::*;

    localparam int PW    = $clog2(NUM_TABLE_PAGES);
    localparam int AW    = PW + IDX_W;
    localparam int DEPTH = NUM_TABLE_PAGES * 512;

    cfg_t        cfg_reg;
    logic        m_valid_reg;
    result_t     m_res_reg;

    logic        res_valid;
    logic        res_ready;
    result_t     res;
    logic        mem_wr_en;
    logic        mem_rd_en;
    logic [AW-1:0] mem_addr;
    logic [63:0] mem_wdata;
    logic [63:0] mem_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wen) begin
            unique case (cfg_idx)
                REG_REGION_FRAME: cfg_reg.region_frame <= cfg_wdata;
                REG_ROOT_PAGE:    cfg_reg.root_page    <= cfg_wdata[ROOT_W-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // output word register: walker may finish while the previous word waits
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg.addr;
    assign m_tuser  = m_res_reg.status;

    flpt_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .wr_en (mem_wr_en),
        .rd_en (mem_rd_en),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    flpt_walker #(
        .NUM_TABLE_PAGES (NUM_TABLE_PAGES),
        .PW              (PW),
        .AW              (AW)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_va     (s_tdata[47:0]),
        .in_pf     (s_tdata[83:48]),
        .in_af     (s_tdata[85:84]),
        .in_count  (s_tdata[101:86]),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_wr_en (mem_wr_en),
        .mem_rd_en (mem_rd_en),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

endmodule

// ===== sv/flpt_checker.sv =====
// ----------------------------------------------------------------------------
// flpt_checker
// Port-level checks of the page table engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "four_level_page_table_engine_unit_defines.svh"

module flpt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import flpt_pkg::*;

    // stalled result word holds
    `FLPT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    // one command in flight at a time
    `FLPT_ASSERT_NEXT(a_one_cmd, s_tvalid && s_tready, !s_tready, "second word taken while busy")

    `FLPT_ASSERT_IMPL(a_nm_zero, m_tvalid && m_tuser == STS_NOT_MAPPED, m_tdata == 48'd0, "not mapped result with nonzero address")

    // exhaustion only comes from map, which reports a page address
    `FLPT_ASSERT_IMPL(a_exh_align, m_tvalid && m_tuser == STS_EXHAUSTED, m_tdata[11:0] == 12'd0, "exhausted result not page aligned")

endmodule

bind four_level_page_table_engine_unit flpt_checker u_flpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the four-level page table engine. A clocked driver
// feeds map, unmap and translate commands from a backlog queue. A clocked
// monitor checks each result word against an in-bench table walker that keeps
// its own copy of the table store, bump allocator and registers. Both sides
// idle at random, and the receiver stalls for long stretches now and then.
// ----------------------------------------------------------------------------
module tb;
    import flpt_pkg::*;

    localparam int TABLE_PAGES   = 64;
    localparam int STORE_WORDS   = TABLE_PAGES * 512;
    localparam int RUN_LIMIT     = 3_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [VA_W-1:0]    va;
        logic [FRAME_W-1:0] pf;
        logic [1:0]         af;
        logic [15:0]        cnt;
    } pt_cmd_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata   = '0;
    logic [1:0]   s_tuser   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [47:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_wen   = 1'b0;
    logic         cfg_idx   = 1'b0;
    logic [35:0]  cfg_wdata = '0;

    four_level_page_table_engine_unit #(
        .NUM_TABLE_PAGES(TABLE_PAGES)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_wen  (cfg_wen),
        .cfg_idx  (cfg_idx),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // walker state
    logic [PTE_W-1:0]   pt_store [STORE_WORDS];
    int unsigned        pool_next;
    logic [FRAME_W-1:0] region_q;
    logic [ROOT_W-1:0]  root_q;

    pt_cmd_t     cmd_backlog[$];
    result_t     due_results[$];
    pt_cmd_t     on_bus;
    int unsigned tx_gap;
    bit          tx_bursty;
    int unsigned rx_wait;
    bit          rx_bursty;
    int unsigned hold_left;
    int unsigned words_in;
    int unsigned mismatches;
    int unsigned cycle_count = 0;
    logic [26:0] hot_path [6];

    // entry frame -> store page, only when it falls inside the table region
    function automatic bit frame_to_page(input logic [PTE_W-1:0] e, output int unsigned pg);
        logic [FRAME_W-1:0] off;
        off = e[47:12] - region_q;
        pg  = off[31:0];
        return (off < FRAME_W'(TABLE_PAGES));
    endfunction

    function automatic bit descend_or_alloc(input int unsigned pg, input logic [IDX_W-1:0] idx,
                                            input logic [PTE_W-1:0] fl,
                                            output int unsigned child);
        int unsigned        slot;
        int unsigned        fresh;
        int unsigned        k;
        logic [FRAME_W-1:0] fresh_frame;
        logic [PTE_W-1:0]   e;
        slot = pg * 512 + idx;
        if (pt_store[slot][0]) begin
            if (frame_to_page(pt_store[slot], child)) begin
                pt_store[slot] |= fl;
                return 1'b1;
            end
        end
        if (pool_next >= TABLE_PAGES)
            return 1'b0;
        fresh = pool_next;
        pool_next++;
        for (k = 0; k < 512; k++)
            pt_store[fresh * 512 + k] = '0;
        fresh_frame = region_q + FRAME_W'(fresh);
        e = '0;
        e[47:12] = fresh_frame;
        pt_store[slot] = e | fl | 64'd1;
        child = fresh;
        return 1'b1;
    endfunction

    function automatic bit descend_present(input int unsigned pg, input logic [IDX_W-1:0] idx,
                                           output int unsigned child);
        logic [PTE_W-1:0] e;
        e = pt_store[pg * 512 + idx];
        child = 0;
        if (!e[0])
            return 1'b0;
        return frame_to_page(e, child);
    endfunction

    task automatic walk_tables(input pt_cmd_t c, output result_t r);
        logic [VA_W-1:0]    va;
        logic [FRAME_W-1:0] pf;
        logic [PTE_W-1:0]   fl;
        logic [PTE_W-1:0]   e;
        int unsigned        l3, l2, l1, cur, n;
        bit                 ok;
        r.status = STS_OK;
        r.addr   = '0;
        va = {c.va[47:12], 12'h000};
        pf = c.pf;
        fl = '0;
        fl[1] = c.af[0];
        fl[2] = c.af[1];
        case (c.cmd)
            CMD_MAP: begin
                for (n = 0; n < c.cnt; n++) begin
                    ok = (root_q < TABLE_PAGES);
                    if (ok) ok = descend_or_alloc(32'(root_q), va[47:39], fl, l3);
                    if (ok) ok = descend_or_alloc(l3, va[38:30], fl, l2);
                    if (ok) ok = descend_or_alloc(l2, va[29:21], fl, l1);
                    if (!ok) begin
                        r.status = STS_EXHAUSTED;
                        break;
                    end
                    e = '0;
                    e[47:12] = pf;
                    pt_store[l1 * 512 + va[20:12]] = e | fl | 64'd1;
                    va = va + 48'h1000;
                    pf = pf + 1'b1;
                end
                r.addr = va;
            end
            CMD_UNMAP: begin
                for (n = 0; n < c.cnt; n++) begin
                    ok = (root_q < TABLE_PAGES);
                    if (ok) ok = descend_present(32'(root_q), va[47:39], l3);
                    if (ok) ok = descend_present(l3, va[38:30], l2);
                    if (ok) ok = descend_present(l2, va[29:21], l1);
                    if (ok) pt_store[l1 * 512 + va[20:12]] = '0;
                    va = va + 48'h1000;
                end
                r.addr = va;
            end
            CMD_XLATE: begin
                cur = 32'(root_q);
                ok  = (root_q < TABLE_PAGES);
                // intermediate levels follow any nonzero entry, present or not
                for (n = 0; n < 3 && ok; n++) begin
                    e = pt_store[cur * 512 + c.va[(39 - 9 * n) +: 9]];
                    if (e == '0)
                        ok = 1'b0;
                    else if (!frame_to_page(e, cur))
                        ok = 1'b0;
                end
                if (ok) begin
                    e = pt_store[cur * 512 + c.va[20:12]];
                    if (e[0])
                        r.addr = {e[47:12], c.va[11:0]};
                    else
                        ok = 1'b0;
                end
                if (!ok) begin
                    r.status = STS_NOT_MAPPED;
                    r.addr   = '0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic void queue_cmd(input logic [1:0] cmd, input logic [47:0] va,
                                      input logic [35:0] pf, input logic [1:0] af,
                                      input logic [15:0] cnt);
        pt_cmd_t c;
        c.cmd = cmd;
        c.va  = va;
        c.pf  = pf;
        c.af  = af;
        c.cnt = cnt;
        cmd_backlog.push_back(c);
    endfunction

    // mostly a handful of hot 2 MiB regions so tables get reused after the pool drains
    function automatic logic [47:0] pick_va();
        logic [47:0] va;
        va = 48'({$urandom, $urandom});
        if ($urandom_range(0, 9) != 0) begin
            va[47:21] = hot_path[$urandom_range(0, 5)];
            if ($urandom_range(0, 4) != 0)
                va[20:12] = 9'($urandom_range(0, 31));
        end
        return va;
    endfunction

    function automatic void fill_random(input int unsigned n);
        int unsigned roll;
        logic [1:0]  cmd;
        logic [35:0] pf;
        logic [15:0] cnt;
        repeat (n) begin
            roll = $urandom_range(0, 99);
            if (roll < 40)      cmd = CMD_MAP;
            else if (roll < 60) cmd = CMD_UNMAP;
            else if (roll < 97) cmd = CMD_XLATE;
            else                cmd = CMD_UNKNOWN;
            pf = 36'({$urandom, $urandom});
            // frames inside the table region alias leaves onto table pages
            if ($urandom_range(0, 4) == 0)
                pf = region_q + FRAME_W'($urandom_range(0, TABLE_PAGES - 1));
            cnt = 16'($urandom);
            if (cmd == CMD_MAP || cmd == CMD_UNMAP) begin
                roll = $urandom_range(0, 99);
                if (roll < 5)       cnt = 16'd0;
                else if (roll < 80) cnt = 16'($urandom_range(1, 4));
                else if (roll < 97) cnt = 16'($urandom_range(5, 16));
                else                cnt = 16'($urandom_range(17, 48));
            end
            queue_cmd(cmd, pick_va(), pf, 2'($urandom_range(0, 3)), cnt);
        end
    endfunction

    task automatic write_reg(input logic idx, input logic [35:0] val);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        if (idx == REG_REGION_FRAME)
            region_q = val;
        else
            root_q = val[ROOT_W-1:0];
    endtask

    task automatic wait_idle();
        do
            @(negedge aclk);
        while (cmd_backlog.size() != 0 || s_tvalid || due_results.size() != 0);
    endtask

    // driver
    always @(posedge aclk) begin
        result_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                walk_tables(on_bus, r);
                due_results.push_back(r);
                if ($urandom_range(0, 39) == 0)
                    tx_bursty = !tx_bursty;
                tx_gap = tx_bursty ? $urandom_range(0, 8) : 0;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    on_bus = cmd_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, on_bus.cnt, on_bus.af, on_bus.pf, on_bus.va};
                    s_tuser  <= on_bus.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word: status %0d addr %h",
                                            m_tuser, m_tdata));
                end else begin
                    want = due_results.pop_front();
                    if (m_tuser !== want.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                m_tuser, want.status));
                    if (m_tdata !== want.addr)
                        flag_mismatch($sformatf("addr %h, expected %h",
                                                m_tdata, want.addr));
                end
                if ($urandom_range(0, 39) == 0)
                    rx_bursty = !rx_bursty;
                rx_wait = rx_bursty ? $urandom_range(0, 8) : 0;
            end
            if (hold_left != 0 || rx_wait != 0) begin
                m_tready <= 1'b0;
                if (rx_wait != 0)
                    rx_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // long back-pressure windows so the engine backs up into s_tready
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            words_in  <= 0;
        end else begin
            if (s_tvalid && s_tready)
                words_in <= words_in + 1;
            if (hold_left != 0)
                hold_left <= hold_left - 1;
            else if (s_tvalid && s_tready && (words_in == 60 || words_in == 900))
                hold_left <= HOLD_CYCLES;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("** four_level_page_table_engine_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        int unsigned k;
        logic [35:0] far_region;
        for (k = 0; k < STORE_WORDS; k++)
            pt_store[k] = '0;
        pool_next   = 1;
        region_q    = '0;
        root_q      = '0;
        mismatches  = 0;
        tx_bursty   = 1'b1;
        rx_bursty   = 1'b1;
        hot_path[0] = 27'($urandom);
        hot_path[1] = {hot_path[0][26:9], 9'($urandom)};
        hot_path[2] = {hot_path[0][26:18], 18'($urandom)};
        hot_path[3] = '1;
        hot_path[4] = '0;
        hot_path[5] = 27'($urandom);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        write_reg(REG_REGION_FRAME, '0);
        write_reg(REG_ROOT_PAGE, '0);

        // directed: empty store, unaligned runs, wrap, empty run, flag merge,
        // 2 MiB boundary crossing, partial unmap, unknown command
        queue_cmd(CMD_XLATE,   48'h0000_0000_0000, 36'h0,           2'd0, 16'd0);
        queue_cmd(CMD_UNMAP,   48'h0000_0000_0FFF, 36'h0,           2'd0, 16'd3);
        queue_cmd(CMD_MAP,     48'h0000_0000_0123, 36'h0,           2'd0, 16'd1);
        queue_cmd(CMD_XLATE,   48'h0000_0000_0ABC, 36'h0,           2'd0, 16'd0);
        queue_cmd(CMD_MAP,     48'hFFFF_FFFF_F000, 36'hF_FFFF_FFFF, 2'd3, 16'd2);
        queue_cmd(CMD_XLATE,   48'hFFFF_FFFF_FFFF, 36'h0,           2'd0, 16'd0);
        queue_cmd(CMD_XLATE,   48'h0000_0000_0000, 36'h0,           2'd0, 16'd0);
        queue_cmd(CMD_MAP,     48'h5555_5555_5FFF, 36'h1,           2'd1, 16'd0);
        queue_cmd(CMD_UNMAP,   48'h0000_0000_0000, 36'h0,           2'd0, 16'd1);
        queue_cmd(CMD_XLATE,   48'h0000_0000_0010, 36'h0,           2'd0, 16'd0);
        queue_cmd(CMD_UNKNOWN, 48'hFFFF_FFFF_FFFF, 36'hF_FFFF_FFFF, 2'd3, 16'hFFFF);
        queue_cmd(CMD_MAP,     48'h0000_0000_2000, 36'h0_0000_1234, 2'd1, 16'd1);
        queue_cmd(CMD_MAP,     48'h0000_0000_3000, 36'h0_0000_1235, 2'd2, 16'd1);
        queue_cmd(CMD_XLATE,   48'h0000_0000_3FFF, 36'h0,           2'd0, 16'd0);
        queue_cmd(CMD_MAP,     48'h0000_001F_F000, 36'hA_BCDE_F012, 2'd3, 16'd16);
        queue_cmd(CMD_UNMAP,   48'h0000_0020_3000, 36'h0,           2'd0, 16'd8);
        queue_cmd(CMD_XLATE,   48'h0000_0020_2345, 36'h0,           2'd0, 16'd0);
        queue_cmd(CMD_XLATE,   48'h0000_0020_5000, 36'h0,           2'd0, 16'd0);
        queue_cmd(CMD_XLATE,   48'h0000_0000_3000, 36'hF_FFFF_FFFF, 2'd3, 16'hFFFF);
        queue_cmd(CMD_MAP,     48'h8000_0000_0000, 36'h5_A5A5_A5A5, 2'd2, 16'd4);
        queue_cmd(CMD_XLATE,   48'h8000_0000_3123, 36'h0,           2'd0, 16'd0);
        queue_cmd(CMD_MAP,     48'hAAAA_AAAA_A000, 36'h0_0000_0002, 2'd1, 16'd1);
        wait_idle();

        fill_random(500);
        wait_idle();

        write_reg(REG_REGION_FRAME, '1);
        write_reg(REG_ROOT_PAGE, 36'd63);
        fill_random(350);
        wait_idle();

        // far region: every old entry now points outside the store
        far_region = {1'b1, 35'($urandom)};
        write_reg(REG_REGION_FRAME, far_region);
        write_reg(REG_ROOT_PAGE, 36'($urandom_range(0, 63)));
        // longest run; with the pool drained it stops at its first page
        if (pool_next >= TABLE_PAGES)
            queue_cmd(CMD_MAP, pick_va(), 36'({$urandom, $urandom}), 2'd3, 16'hFFFF);
        fill_random(350);
        wait_idle();

        write_reg(REG_REGION_FRAME, '0);
        write_reg(REG_ROOT_PAGE, '0);
        fill_random(400);
        wait_idle();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("** four_level_page_table_engine_unit: PASSED **");
        end else begin
            $display("** four_level_page_table_engine_unit: FAILED **");
        end
        $finish;
    end

endmodule
